// ===== rtl/rpc_pkg.sv =====
// Shared types, constants and elaboration-time functions of the rectangular/polar converter.
package rpc_pkg;

    // Action codes
    localparam logic [1:0] ACT_RECT  = 2'd0;
    localparam logic [1:0] ACT_POLAR = 2'd1;

    // Extra coordinate bits above the fraction: 17-bit results plus CORDIC growth
    localparam int XW_MARGIN  = 19;
    // Square root lane: radicand x*x+y*y stays below 2^32
    localparam int SQ_W       = 32;
    localparam int SQRT_STEPS = 16;
    // Signed 16-bit operand times 33-bit signed inverse gain
    localparam int PROD_W     = 49;
    // Angle word inside the CORDIC, 2^31 = pi
    localparam int ZW         = 32;

    // round(atan(2^-i) * 2^31 / pi)
    localparam logic [ZW-1:0] ATAN_TAB [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef struct packed {
        logic       valid;
        logic [1:0] act;
        logic       origin;
    } ctrl_t;

    // Floor square root of a 64-bit value, bit by bit
    function automatic logic [63:0] isqrt64(logic [63:0] n);
        logic [63:0] r;
        logic [63:0] rem;
        logic [63:0] b;
        r   = '0;
        rem = n;
        b   = 64'h4000_0000_0000_0000;
        for (int k = 0; k < 32; k++) begin
            if (rem >= r + b) begin
                rem = rem - (r + b);
                r   = (r >> 1) + b;
            end
            else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Inverse CORDIC gain in Q32; long division done by shift and subtract
    function automatic logic [31:0] inv_gain_q32(int iters);
        logic [63:0] p;
        logic [63:0] g;
        logic [63:0] num;
        logic [63:0] rem;
        logic [63:0] q;
        p = 64'h1000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (i < iters) begin
                p = p + (p >> (2 * i));
            end
        end
        g = isqrt64(p);
        if (g == 64'd0) begin
            g = 64'd1;
        end
        num = 64'h4000_0000_0000_0000 + (g >> 1);
        rem = '0;
        q   = '0;
        for (int k = 0; k < 64; k++) begin
            rem = {rem[62:0], num[63]};
            num = num << 1;
            if (rem >= g) begin
                rem = rem - g;
                q   = {q[62:0], 1'b1};
            end
            else begin
                q = {q[62:0], 1'b0};
            end
        end
        return q[31:0];
    endfunction

endpackage

// ===== rtl/rpc_prep.sv =====
// Front end: operand squares and gain product, then CORDIC start vector and radicand.
module rpc_prep #(
    parameter int DATA_WIDTH = 16,
    parameter int ITERATIONS = 16
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          in_valid,
    input  logic [1:0]                                    action,
    input  logic signed [15:0]                            first_operand,
    input  logic signed [15:0]                            second_operand,
    output rpc_pkg::ctrl_t                                ctrl,
    output logic signed [DATA_WIDTH+rpc_pkg::XW_MARGIN-1:0] x,
    output logic signed [DATA_WIDTH+rpc_pkg::XW_MARGIN-1:0] y,
    output logic [rpc_pkg::ZW-1:0]                        z,
    output logic [rpc_pkg::SQ_W-1:0]                      rem,
    output logic [rpc_pkg::SQ_W-1:0]                      root
);
    import rpc_pkg::*;

    localparam int XW = DATA_WIDTH + XW_MARGIN;
    localparam logic [31:0] INV_GAIN = inv_gain_q32(ITERATIONS);

    // stage 0
    logic                     valid0_reg;
    logic [1:0]               act0_reg;
    logic signed [15:0]       a0_reg;
    logic signed [15:0]       b0_reg;
    logic [SQ_W-1:0]          sqa0_reg;
    logic [SQ_W-1:0]          sqb0_reg;
    logic signed [PROD_W-1:0] prod0_reg;
    logic signed [31:0]       sqa_next;
    logic signed [31:0]       sqb_next;
    logic signed [PROD_W-1:0] prod_next;

    // stage 1
    ctrl_t                    ctrl1_reg;
    ctrl_t                    ctrl1_next;
    logic signed [XW-1:0]     x1_reg;
    logic signed [XW-1:0]     x1_next;
    logic signed [XW-1:0]     y1_reg;
    logic signed [XW-1:0]     y1_next;
    logic [ZW-1:0]            z1_reg;
    logic [ZW-1:0]            z1_next;
    logic [SQ_W-1:0]          rem1_reg;
    logic [SQ_W-1:0]          rem1_next;

    logic signed [XW-1:0]     ax;
    logic signed [XW-1:0]     bx;
    logic                     flip;
    logic signed [PROD_W-1:0] pr;
    logic signed [PROD_W-1:0] psh;

    assign sqa_next  = first_operand * first_operand;
    assign sqb_next  = second_operand * second_operand;
    assign prod_next = first_operand * $signed({1'b0, INV_GAIN});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid0_reg <= 1'b0;
            act0_reg   <= ACT_RECT;
        end
        else
        begin
            valid0_reg <= in_valid;
            act0_reg   <= action;
        end
    end

    always_ff @(posedge clk)
    begin
        a0_reg    <= first_operand;
        b0_reg    <= second_operand;
        sqa0_reg  <= SQ_W'(unsigned'(sqa_next));
        sqb0_reg  <= SQ_W'(unsigned'(sqb_next));
        prod0_reg <= prod_next;
    end

    always_comb
    begin
        ax   = $signed({{(XW-16){a0_reg[15]}}, a0_reg}) <<< DATA_WIDTH;
        bx   = $signed({{(XW-16){b0_reg[15]}}, b0_reg}) <<< DATA_WIDTH;
        // angle beyond a quarter turn: turn by pi, negate r
        flip = (b0_reg > 16'sd16384) || (b0_reg < -16'sd16384);
        pr   = flip ? -prod0_reg : prod0_reg;
        psh  = pr >>> (32 - DATA_WIDTH);

        rem1_next         = sqa0_reg + sqb0_reg;
        ctrl1_next.valid  = valid0_reg;
        ctrl1_next.act    = act0_reg;
        ctrl1_next.origin = (a0_reg == 16'sd0) && (b0_reg == 16'sd0);

        unique case (act0_reg)
            ACT_POLAR:
            begin
                x1_next = XW'(psh);
                y1_next = '0;
                z1_next = {b0_reg[15] ^ flip, b0_reg[14:0], 16'h0000};
            end
            default:
            begin
                // left half plane: start turned by pi
                if (a0_reg[15])
                begin
                    x1_next = -ax;
                    y1_next = -bx;
                    z1_next = 32'h8000_0000;
                end
                else
                begin
                    x1_next = ax;
                    y1_next = bx;
                    z1_next = '0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl1_reg <= '0;
        end
        else
        begin
            ctrl1_reg <= ctrl1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x1_reg   <= x1_next;
        y1_reg   <= y1_next;
        z1_reg   <= z1_next;
        rem1_reg <= rem1_next;
    end

    assign ctrl = ctrl1_reg;
    assign x    = x1_reg;
    assign y    = y1_reg;
    assign z    = z1_reg;
    assign rem  = rem1_reg;
    assign root = '0;

endmodule

// ===== rtl/rpc_stage.sv =====
// One pipeline stage: a CORDIC micro-rotation and one square root digit step, each a pass-through past its lane.
module rpc_stage #(
    parameter int DATA_WIDTH = 16,
    parameter int ITERATIONS = 16,
    parameter int STAGE      = 0
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  rpc_pkg::ctrl_t                                ctrl_in,
    input  logic signed [DATA_WIDTH+rpc_pkg::XW_MARGIN-1:0] x_in,
    input  logic signed [DATA_WIDTH+rpc_pkg::XW_MARGIN-1:0] y_in,
    input  logic [rpc_pkg::ZW-1:0]                        z_in,
    input  logic [rpc_pkg::SQ_W-1:0]                      rem_in,
    input  logic [rpc_pkg::SQ_W-1:0]                      root_in,
    output rpc_pkg::ctrl_t                                ctrl_out,
    output logic signed [DATA_WIDTH+rpc_pkg::XW_MARGIN-1:0] x_out,
    output logic signed [DATA_WIDTH+rpc_pkg::XW_MARGIN-1:0] y_out,
    output logic [rpc_pkg::ZW-1:0]                        z_out,
    output logic [rpc_pkg::SQ_W-1:0]                      rem_out,
    output logic [rpc_pkg::SQ_W-1:0]                      root_out
);
    import rpc_pkg::*;

    localparam int XW = DATA_WIDTH + XW_MARGIN;

    ctrl_t                ctrl_reg;
    logic signed [XW-1:0] x_reg;
    logic signed [XW-1:0] x_next;
    logic signed [XW-1:0] y_reg;
    logic signed [XW-1:0] y_next;
    logic [ZW-1:0]        z_reg;
    logic [ZW-1:0]        z_next;
    logic [SQ_W-1:0]      rem_reg;
    logic [SQ_W-1:0]      rem_next;
    logic [SQ_W-1:0]      root_reg;
    logic [SQ_W-1:0]      root_next;

    generate
        if (STAGE < ITERATIONS)
        begin : g_rot
            logic signed [XW-1:0] xs;
            logic signed [XW-1:0] ys;
            logic                 plus;

            always_comb
            begin
                xs = x_in >>> STAGE;
                ys = y_in >>> STAGE;
                // vectoring steers by sign of y, rotation by sign of z
                plus = (ctrl_in.act == ACT_RECT) ? !y_in[XW-1] : z_in[ZW-1];
                if (plus)
                begin
                    x_next = x_in + ys;
                    y_next = y_in - xs;
                    z_next = z_in + ATAN_TAB[STAGE];
                end
                else
                begin
                    x_next = x_in - ys;
                    y_next = y_in + xs;
                    z_next = z_in - ATAN_TAB[STAGE];
                end
            end
        end
        else
        begin : g_rot_pass
            assign x_next = x_in;
            assign y_next = y_in;
            assign z_next = z_in;
        end

        if (STAGE < SQRT_STEPS)
        begin : g_sqrt
            localparam logic [SQ_W-1:0] SQ_BIT = SQ_W'(1) << (30 - 2 * STAGE);
            logic [SQ_W-1:0] trial;

            always_comb
            begin
                trial = root_in + SQ_BIT;
                if (rem_in >= trial)
                begin
                    rem_next  = rem_in - trial;
                    root_next = (root_in >> 1) + SQ_BIT;
                end
                else
                begin
                    rem_next  = rem_in;
                    root_next = root_in >> 1;
                end
            end
        end
        else
        begin : g_sqrt_pass
            assign rem_next  = rem_in;
            assign root_next = root_in;
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign ctrl_out = ctrl_reg;
    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule

// ===== rtl/rpc_post.sv =====
// Back end: rounding of magnitude, angle and coordinates into the result registers.
module rpc_post #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  rpc_pkg::ctrl_t                                ctrl,
    input  logic signed [DATA_WIDTH+rpc_pkg::XW_MARGIN-1:0] x,
    input  logic signed [DATA_WIDTH+rpc_pkg::XW_MARGIN-1:0] y,
    input  logic [rpc_pkg::ZW-1:0]                        z,
    input  logic [rpc_pkg::SQ_W-1:0]                      rem,
    input  logic [rpc_pkg::SQ_W-1:0]                      root,
    output logic                                          done,
    output logic signed [16:0]                            first_result,
    output logic signed [16:0]                            second_result,
    output logic                                          mode_error
);
    import rpc_pkg::*;

    localparam int XW = DATA_WIDTH + XW_MARGIN;
    localparam logic signed [XW-1:0] HALF = XW'(1) <<< (DATA_WIDTH - 1);

    logic                 done_reg;
    logic                 done_next;
    logic                 mode_error_reg;
    logic                 mode_error_next;
    logic signed [16:0]   first_reg;
    logic signed [16:0]   first_next;
    logic signed [16:0]   second_reg;
    logic signed [16:0]   second_next;

    logic signed [XW-1:0] xr;
    logic signed [XW-1:0] yr;
    logic [ZW-1:0]        zr;
    logic [15:0]          ang;
    logic signed [16:0]   ang_ext;
    logic [16:0]          mag;

    always_comb
    begin
        xr  = x + HALF;
        yr  = y + HALF;
        zr  = z + 32'h0000_8000;
        ang = zr[31:16];
        // +pi stays positive, everything above reads as negative
        ang_ext = (ang == 16'h8000) ? 17'sd32768 : $signed({ang[15], ang});
        // round half up: remainder beyond root
        mag = root[16:0] + 17'(rem > root);

        done_next       = ctrl.valid;
        mode_error_next = 1'b0;
        unique case (ctrl.act)
            ACT_RECT:
            begin
                first_next  = $signed(mag);
                second_next = ctrl.origin ? 17'sd0 : ang_ext;
            end
            ACT_POLAR:
            begin
                first_next  = xr[DATA_WIDTH+16:DATA_WIDTH];
                second_next = yr[DATA_WIDTH+16:DATA_WIDTH];
            end
            default:
            begin
                first_next      = '0;
                second_next     = '0;
                mode_error_next = ctrl.valid;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg       <= 1'b0;
            mode_error_reg <= 1'b0;
        end
        else
        begin
            done_reg       <= done_next;
            mode_error_reg <= mode_error_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg  <= first_next;
        second_reg <= second_next;
    end

    assign done          = done_reg;
    assign mode_error    = mode_error_reg;
    assign first_result  = first_reg;
    assign second_result = second_reg;

endmodule

// ===== rtl/rect_polar_converter_core.sv =====
// Top level of the pipelined rectangular/polar converter (CORDIC plus square root lane).
//
//  channel   direction  handshake            word
//  --------  ---------  -------------------  ------------------------------------------
//  command   in         start & !busy        action, first_operand, second_operand
//  result    out        done (one cycle)     first_result, second_result, mode_error
//
// The pipeline has two front-end stages, one stage per CORDIC micro-rotation or
// square root digit, and one rounding stage. The longer of the two lanes sets
// the depth. A new word is taken every cycle; busy is tied low since nothing
// downstream can stall. Reset clears the valid bits of every stage; data
// registers are not reset.
//
// Rectangular to polar: magnitude is round(sqrt(x*x+y*y)) from an exact restoring
// square root, angle is atan2(y,x) in binary units (32768 = pi) from a vectoring
// CORDIC, zero at the origin. Polar to rectangular: rotation CORDIC on a start
// vector prescaled by the inverse gain. Codes 2 and 3 give zeros and mode_error.
module rect_polar_converter_core #(
    parameter int DATA_WIDTH = 16,
    parameter int ITERATIONS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         action,
    input  logic signed [15:0] first_operand,
    input  logic signed [15:0] second_operand,
    output logic               done,
    output logic signed [16:0] first_result,
    output logic signed [16:0] second_result,
    output logic               mode_error
);
    import rpc_pkg::*;

    localparam int XW    = DATA_WIDTH + XW_MARGIN;
    // pipeline depth between front end and rounding stage
    localparam int DEPTH = (ITERATIONS > SQRT_STEPS) ? ITERATIONS : SQRT_STEPS;
    localparam int LAT   = DEPTH + 3;

    logic                 accept;

    // link k feeds stage k; link DEPTH feeds the rounding stage
    ctrl_t                link_ctrl [DEPTH+1];
    logic signed [XW-1:0] link_x    [DEPTH+1];
    logic signed [XW-1:0] link_y    [DEPTH+1];
    logic [ZW-1:0]        link_z    [DEPTH+1];
    logic [SQ_W-1:0]      link_rem  [DEPTH+1];
    logic [SQ_W-1:0]      link_root [DEPTH+1];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    rpc_prep #(
        .DATA_WIDTH (DATA_WIDTH),
        .ITERATIONS (ITERATIONS)
    ) u_prep (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (accept),
        .action         (action),
        .first_operand  (first_operand),
        .second_operand (second_operand),
        .ctrl           (link_ctrl[0]),
        .x              (link_x[0]),
        .y              (link_y[0]),
        .z              (link_z[0]),
        .rem            (link_rem[0]),
        .root           (link_root[0])
    );

    generate
        for (genvar g = 0; g < DEPTH; g++)
        begin : g_stage
            rpc_stage #(
                .DATA_WIDTH (DATA_WIDTH),
                .ITERATIONS (ITERATIONS),
                .STAGE      (g)
            ) u_stage (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl_in  (link_ctrl[g]),
                .x_in     (link_x[g]),
                .y_in     (link_y[g]),
                .z_in     (link_z[g]),
                .rem_in   (link_rem[g]),
                .root_in  (link_root[g]),
                .ctrl_out (link_ctrl[g+1]),
                .x_out    (link_x[g+1]),
                .y_out    (link_y[g+1]),
                .z_out    (link_z[g+1]),
                .rem_out  (link_rem[g+1]),
                .root_out (link_root[g+1])
            );
        end
    endgenerate

    rpc_post #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_post (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (link_ctrl[DEPTH]),
        .x             (link_x[DEPTH]),
        .y             (link_y[DEPTH]),
        .z             (link_z[DEPTH]),
        .rem           (link_rem[DEPTH]),
        .root          (link_root[DEPTH]),
        .done          (done),
        .first_result  (first_result),
        .second_result (second_result),
        .mode_error    (mode_error)
    );

    // every result traces back to a word that was accepted earlier
    a_done_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LAT))
        else $error("result without a matching command");

    // error flag follows the action code of that word
    a_err_matches: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (mode_error == $past(action[1], LAT)))
        else $error("mode_error does not match the action code");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && mode_error) |-> (first_result == 17'sd0 && second_result == 17'sd0))
        else $error("invalid action gave nonzero results");

    a_origin_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(action == ACT_RECT && first_operand == 16'sd0
                       && second_operand == 16'sd0, LAT))
        |-> (first_result == 17'sd0 && second_result == 17'sd0))
        else $error("origin did not give zero magnitude and angle");

endmodule

// ===== verif/rect_polar_converter_core_tb.sv =====
// Self-checking testbench for rect_polar_converter_core: directed table, then random words.
module rect_polar_converter_core_tb;

    import rpc_pkg::*;

    // Block configuration; the predictor below follows the same values
    localparam int FRAC      = 16;
    localparam int ROTATIONS = 16;
    localparam int LATENCY   = ((ROTATIONS > 16) ? ROTATIONS : 16) + 3;

    // Codes 2 and 3 carry no meaning and must come back as a mode error
    localparam logic [1:0] ACT_BAD_2 = 2'd2;
    localparam logic [1:0] ACT_BAD_3 = 2'd3;

    localparam int RANDOM_WORDS   = 1200;
    // Sender never idles inside this window of word numbers
    localparam int QUIET_FROM     = 400;
    localparam int QUIET_TO       = 700;
    // At this word the sender holds off until the pipeline has drained
    localparam int DRAIN_AT       = 900;
    localparam int WATCHDOG_LIMIT = 5000;

    localparam longint ONE = longint'(1) << FRAC;

    // round(atan(2^-i) * 2^31 / pi), angle word of the micro-rotations
    localparam bit [31:0] ARCTAN_Q31 [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef struct packed {
        logic signed [16:0] first;
        logic signed [16:0] second;
        logic               err;
    } point_res_t;

    localparam point_res_t ZERO_RES    = '{first: '0, second: '0, err: 1'b0};
    localparam point_res_t INVALID_RES = '{first: '0, second: '0, err: 1'b1};

    // One directed row: command word, and a typed expectation when typed is set
    typedef struct packed {
        logic [1:0]         act;
        logic signed [15:0] fo;
        logic signed [15:0] so;
        logic               typed;
        point_res_t         res;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 24;

    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{ACT_RECT,  16'sd0,      16'sd0,      1'b1, ZERO_RES},     // origin
        '{ACT_RECT,  16'sh7FFF,   16'sd0,      1'b0, ZERO_RES},
        '{ACT_RECT,  16'sh8000,   16'sd0,      1'b0, ZERO_RES},     // angle pi
        '{ACT_RECT,  16'sd0,      16'sh7FFF,   1'b0, ZERO_RES},
        '{ACT_RECT,  16'sd0,      16'sh8000,   1'b0, ZERO_RES},
        '{ACT_RECT,  16'sh8000,   16'sh8000,   1'b0, ZERO_RES},     // largest magnitude
        '{ACT_RECT,  16'sh7FFF,   16'sh8000,   1'b0, ZERO_RES},
        '{ACT_RECT,  -16'sd1,     16'sd1,      1'b0, ZERO_RES},     // left half plane
        '{ACT_RECT,  -16'sd1,     -16'sd1,     1'b0, ZERO_RES},
        '{ACT_RECT,  -16'sd100,   16'sd0,      1'b0, ZERO_RES},
        '{ACT_RECT,  16'sd1,      16'sd0,      1'b0, ZERO_RES},
        '{ACT_POLAR, 16'sd0,      16'sd12345,  1'b1, ZERO_RES},     // zero radius
        '{ACT_POLAR, 16'sh7FFF,   16'sd0,      1'b0, ZERO_RES},
        '{ACT_POLAR, 16'sh8000,   16'sd0,      1'b0, ZERO_RES},
        '{ACT_POLAR, 16'sh7FFF,   16'sd16384,  1'b0, ZERO_RES},     // exactly a quarter
        '{ACT_POLAR, 16'sh7FFF,   16'sd16385,  1'b0, ZERO_RES},     // just past it
        '{ACT_POLAR, 16'sh7FFF,   -16'sd16384, 1'b0, ZERO_RES},
        '{ACT_POLAR, 16'sh7FFF,   -16'sd16385, 1'b0, ZERO_RES},
        '{ACT_POLAR, 16'sh7FFF,   16'sh7FFF,   1'b0, ZERO_RES},
        '{ACT_POLAR, 16'sh7FFF,   16'sh8000,   1'b0, ZERO_RES},     // -32768 is pi too
        '{ACT_POLAR, 16'sh8000,   16'sh8000,   1'b0, ZERO_RES},
        '{ACT_BAD_2, 16'sh7FFF,   16'sh8000,   1'b1, INVALID_RES},
        '{ACT_BAD_3, 16'sh8000,   16'sh7FFF,   1'b1, INVALID_RES},
        '{ACT_BAD_2, 16'sd0,      16'sd0,      1'b1, INVALID_RES}
    };

    logic               clk;
    logic               rst_n;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         action = ACT_RECT;
    logic signed [15:0] first_operand = '0;
    logic signed [15:0] second_operand = '0;
    logic               done;
    logic signed [16:0] first_result;
    logic signed [16:0] second_result;
    logic               mode_error;

    point_res_t pending_results [$];
    int         mismatches  = 0;
    int         quiet_cycles = 0;
    int         word_count  = 0;
    longint     inv_gain;

    rect_polar_converter_core #(
        .DATA_WIDTH(FRAC),
        .ITERATIONS(ROTATIONS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .first_operand (first_operand),
        .second_operand(second_operand),
        .done          (done),
        .first_result  (first_result),
        .second_result (second_result),
        .mode_error    (mode_error)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Floor square root, one result bit at a time from the top (n < 2^62 here)
    function automatic longint unsigned floor_root(input longint unsigned n);
        longint unsigned r;
        longint unsigned trial;
        r = 0;
        for (int k = 30; k >= 0; k--)
        begin
            trial = r | (longint'(1) << k);
            if (trial * trial <= n)
                r = trial;
        end
        return r;
    endfunction

    // Q32 inverse of the CORDIC gain: product of (1 + 4^-i) in Q60, root, reciprocal
    function automatic longint gain_inverse_q32(input int steps);
        longint unsigned prod;
        longint unsigned root;
        prod = longint'(1) << 60;
        for (int i = 0; i < steps; i++)
            prod = prod + (prod >> (2 * i));
        root = floor_root(prod);
        if (root == 0)
            root = 1;
        return longint'(((longint'(1) << 62) + root / 2) / root);
    endfunction

    // Expected result word for one command word
    function automatic point_res_t convert_point(input logic [1:0] act,
                                                 input logic signed [15:0] fo,
                                                 input logic signed [15:0] so);
        point_res_t res;
        longint     a;
        longint     b;
        longint     x;
        longint     y;
        longint     dx;
        longint     dy;
        longint     nxt;
        longint     rad;
        longint     mag;
        longint     ang;
        longint     z;
        bit [31:0]  zv;
        res = ZERO_RES;
        a = fo;
        b = so;
        case (act)
            ACT_RECT:
            begin
                // Magnitude: exact root, rounded up when past the half point
                rad = a * a + b * b;
                mag = longint'(floor_root(rad));
                if (rad - mag * mag > mag)
                    mag++;
                res.first = 17'(mag);
                // Origin keeps angle zero; otherwise vectoring CORDIC
                if (a != 0 || b != 0)
                begin
                    x  = a * ONE;
                    y  = b * ONE;
                    zv = '0;
                    if (x < 0)
                    begin
                        // Left half plane: turn by pi first
                        x  = -x;
                        y  = -y;
                        zv = 32'h8000_0000;
                    end
                    for (int i = 0; i < ROTATIONS; i++)
                    begin
                        dx = y >>> i;
                        dy = x >>> i;
                        if (y >= 0)
                        begin
                            x  = x + dx;
                            y  = y - dy;
                            zv = zv + ARCTAN_Q31[i];
                        end
                        else
                        begin
                            x  = x - dx;
                            y  = y + dy;
                            zv = zv - ARCTAN_Q31[i];
                        end
                    end
                    zv  = (zv + 32'h0000_8000) >> 16;
                    ang = longint'(zv[15:0]);
                    if (ang > 32768)
                        ang = ang - 65536;
                    res.second = 17'(ang);
                end
            end
            ACT_POLAR:
            begin
                z = b * 65536;
                // Past a quarter turn: fold by pi and flip the radius
                if (z > (longint'(1) << 30))
                begin
                    z = z - (longint'(1) << 31);
                    a = -a;
                end
                else if (z < -(longint'(1) << 30))
                begin
                    z = z + (longint'(1) << 31);
                    a = -a;
                end
                x = (a * inv_gain) >>> (32 - FRAC);
                y = 0;
                for (int i = 0; i < ROTATIONS; i++)
                begin
                    dx = y >>> i;
                    dy = x >>> i;
                    if (z >= 0)
                    begin
                        nxt = x - dx;
                        y   = y + dy;
                        z   = z - longint'(ARCTAN_Q31[i]);
                    end
                    else
                    begin
                        nxt = x + dx;
                        y   = y - dy;
                        z   = z + longint'(ARCTAN_Q31[i]);
                    end
                    x = nxt;
                end
                res.first  = 17'((x + (ONE >>> 1)) >>> FRAC);
                res.second = 17'((y + (ONE >>> 1)) >>> FRAC);
            end
            default:
                res = INVALID_RES;
        endcase
        return res;
    endfunction

    // Random operand: mostly full range, with extremes, small values and
    // values around a quarter turn mixed in
    function automatic logic signed [15:0] pick_operand();
        case ($urandom_range(9))
            0: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            1: return 16'($urandom_range(64)) - 16'sd32;
            2: return ($urandom_range(1) ? 16'sd16384 : -16'sd16384)
                      + 16'($urandom_range(4)) - 16'sd2;
            default: return 16'($urandom);
        endcase
    endfunction

    // Offer one command word; idle gaps and the drain pause come first.
    // The expectation is queued at the edge that takes the word.
    task automatic send_word(input logic [1:0] act, input logic signed [15:0] fo,
                             input logic signed [15:0] so, input bit typed,
                             input point_res_t typed_res);
        point_res_t want;
        if (word_count == DRAIN_AT)
        begin
            start <= 1'b0;
            do @(posedge clk); while (pending_results.size() != 0);
        end
        else if (!(word_count >= QUIET_FROM && word_count < QUIET_TO)
                 && $urandom_range(99) < 27)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        start          <= 1'b1;
        action         <= act;
        first_operand  <= fo;
        second_operand <= so;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        want = typed ? typed_res : convert_point(act, fo, so);
        pending_results.push_back(want);
        word_count++;
    endtask

    // Stimulus: directed table, random words, then drain and verdict
    initial
    begin
        logic [1:0]         act;
        int                 pick;
        logic signed [15:0] fo;
        logic signed [15:0] so;
        inv_gain = gain_inverse_q32(ROTATIONS);
        wait (rst_n === 1'b1);
        @(posedge clk);

        // Directed rows: typed expectation only where it is obvious
        for (int r = 0; r < DIRECTED_ROWS; r++)
            send_word(DIRECTED[r].act, DIRECTED[r].fo, DIRECTED[r].so,
                      DIRECTED[r].typed, DIRECTED[r].res);

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
                act = ACT_RECT;
            else if (pick < 90)
                act = ACT_POLAR;
            else if (pick < 95)
                act = ACT_BAD_2;
            else
                act = ACT_BAD_3;
            fo = pick_operand();
            so = pick_operand();
            send_word(act, fo, so, 1'b0, ZERO_RES);
        end

        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // Catch stray results trailing the last expected one
        repeat (LATENCY + 20) @(posedge clk);

        if (mismatches == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Result checker and activity tracking, sampled at every rising edge
    always @(posedge clk)
    begin
        point_res_t want;
        point_res_t got;
        got = '{first: first_result, second: second_result, err: mode_error};
        if (rst_n && done === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: first=%0d second=%0d err=%b",
                             got.first, got.second, got.err);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.first !== want.first || got.second !== want.second
                    || got.err !== want.err)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %0d/%0d/%b, got %0d/%0d/%b",
                                 want.first, want.second, want.err,
                                 got.first, got.second, got.err);
                end
            end
        end
        if (rst_n && ((start && busy === 1'b0) || done === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Watchdog: too long with no word taken and no result seen
    initial
    begin
        do @(posedge clk); while (quiet_cycles < WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

endmodule
